// ===== hdl/sae_pkg.sv =====
`timescale 1ns / 1ps

package sae_pkg;

    localparam int LENGTH_BITS    = 20;
    localparam int TABLE_SEGMENTS = 256;
    localparam int TABLE_DEPTH    = TABLE_SEGMENTS + 1;
    localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
    localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
    localparam int PHASE_BITS     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_BITS      = 15;
    localparam int QUEUE_DEPTH    = 2;

    localparam int OP_BITS        = 2;
    localparam int S_TDATA_BITS   = 40;
    localparam int M_TDATA_BITS   = 32;
    localparam int CFG_IDX_BITS   = 4;

    localparam logic [GAIN_BITS-1:0] FULL_LEVEL = '1;

    localparam logic [LENGTH_BITS-1:0] ATTACK_RESET = LENGTH_BITS'(4410);
    localparam logic [LENGTH_BITS-1:0] HOLD_RESET   = '0;
    localparam logic [LENGTH_BITS-1:0] DECAY_RESET  = LENGTH_BITS'(4410);
    localparam logic [LENGTH_BITS-1:0] FADE_RESET   = '0;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE   = CFG_IDX_BITS'(3);

    localparam logic [OP_BITS-1:0] OP_SAMPLE  = OP_BITS'(0);
    localparam logic [OP_BITS-1:0] OP_NOTE_ON = OP_BITS'(1);
    localparam logic [OP_BITS-1:0] OP_TWRITE  = OP_BITS'(2);

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_NOTE_ON,
        CMD_TWRITE
    } t_kind;

    typedef struct packed {
        t_kind                          kind;
        logic signed [SAMPLE_BITS-1:0]  sample;
        logic [TABLE_AW-1:0]            index;
        logic [GAIN_BITS-1:0]           value;
    } t_cmd;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] attack;
        logic [LENGTH_BITS-1:0] hold;
        logic [LENGTH_BITS-1:0] decay;
        logic [LENGTH_BITS-1:0] fade;
    } t_cfg;

endpackage

// ===== hdl/sae_ram.sv =====
`timescale 1ns / 1ps

module sae_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/sae_div.sv =====
`timescale 1ns / 1ps

// Restoring divider: 2^PHASE_BITS / divisor, one quotient bit per cycle.
module sae_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [sae_pkg::LENGTH_BITS-1:0]     i_divisor,
    output logic                                o_done,
    output logic [sae_pkg::PHASE_BITS-1:0]      o_quot
);

    localparam int L     = sae_pkg::LENGTH_BITS;
    localparam int PB    = sae_pkg::PHASE_BITS;
    localparam int STEPS = sae_pkg::PHASE_BITS + 1;
    localparam int CW    = $clog2(STEPS + 1);

    logic                           r_busy;
    logic                           r_done;
    logic                           r_first;
    logic [CW-1:0]                  r_cnt;
    logic [L-1:0]                   r_div;
    logic [L-1:0]                   r_rem;
    // the bit above PHASE_BITS only shows for a divisor of 1, which is handled outside
    logic [PB-1:0]                  r_quot;

    logic [L:0] w_shift;
    logic       w_ge;

    assign w_shift = {r_rem, r_first};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CW'(STEPS - 1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_first <= 1'b1;
                r_div   <= i_divisor;
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_rem   <= w_ge ? L'(w_shift - {1'b0, r_div}) : w_shift[L-1:0];
                r_quot  <= {r_quot[PB-2:0], w_ge};
                r_cnt   <= r_cnt + CW'(1);
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/sae_queue.sv =====
`timescale 1ns / 1ps

module sae_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sae_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sae_pkg::t_cmd o_cmd
);

    localparam int D  = sae_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    sae_pkg::t_cmd  r_slot [D];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == CW'(D));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_slot[r_wp] <= i_cmd;
                r_wp <= (r_wp == PW'(D - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(D - 1)) ? '0 : r_rp + PW'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/sae_front.sv =====
`timescale 1ns / 1ps

// Accept input transactions, drop the ones with no effect, queue the rest.
module sae_front (
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [sae_pkg::S_TDATA_BITS-1:0]    i_tdata,
    input  logic [sae_pkg::OP_BITS-1:0]         i_tuser,
    input  logic                                i_q_full,
    output logic                                o_push,
    output sae_pkg::t_cmd                       o_cmd
);

    localparam int SB = sae_pkg::SAMPLE_BITS;
    localparam int AW = sae_pkg::TABLE_AW;
    localparam int GB = sae_pkg::GAIN_BITS;

    logic w_keep;

    assign o_tready = !i_q_full;

    always_comb begin
        o_cmd.sample = $signed(i_tdata[SB-1:0]);
        o_cmd.index  = i_tdata[SB +: AW];
        o_cmd.value  = i_tdata[SB + AW +: GB];
        o_cmd.kind   = sae_pkg::CMD_SAMPLE;
        w_keep       = 1'b0;
        unique case (i_tuser)
            sae_pkg::OP_SAMPLE: begin
                o_cmd.kind = sae_pkg::CMD_SAMPLE;
                w_keep     = 1'b1;
            end
            sae_pkg::OP_NOTE_ON: begin
                o_cmd.kind = sae_pkg::CMD_NOTE_ON;
                w_keep     = 1'b1;
            end
            sae_pkg::OP_TWRITE: begin
                o_cmd.kind = sae_pkg::CMD_TWRITE;
                // entries past the last segment point do not exist
                w_keep     = (o_cmd.index <= AW'(sae_pkg::TABLE_SEGMENTS));
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_tvalid && !i_q_full && w_keep;

endmodule

// ===== hdl/sae_back.sv =====
`timescale 1ns / 1ps

// Envelope sequencer: stage changes, table interpolation, gain and scaling.
module sae_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sae_pkg::t_cfg                           i_cfg,
    input  logic                                    i_q_valid,
    input  sae_pkg::t_cmd                           i_q_cmd,
    output logic                                    o_q_pop,
    output logic                                    o_tvalid,
    input  logic                                    i_tready,
    output logic signed [sae_pkg::SAMPLE_BITS-1:0]  o_sample,
    output logic [sae_pkg::GAIN_BITS-1:0]           o_gain
);

    localparam int L  = sae_pkg::LENGTH_BITS;
    localparam int PB = sae_pkg::PHASE_BITS;
    localparam int SB = sae_pkg::SAMPLE_BITS;
    localparam int GB = sae_pkg::GAIN_BITS;
    localparam int AW = sae_pkg::TABLE_AW;
    localparam int FB = sae_pkg::FRAC_BITS;
    localparam int XB = sae_pkg::SEG_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ATTACK,
        ST_HOLD,
        ST_DECAY,
        ST_FADE
    } t_stage;

    typedef enum logic [3:0] {
        S_FETCH,
        S_DISPATCH,
        S_DSTART,
        S_DIV,
        S_RDA,
        S_RDB,
        S_MULB,
        S_SUM,
        S_MULG,
        S_EMIT
    } t_state;

    function automatic logic [L-1:0] at_least_two(input logic [L-1:0] n);
        return (n < L'(2)) ? L'(2) : n;
    endfunction

    t_state                 r_state;
    t_stage                 r_stage;
    logic [L-1:0]           r_remaining;
    logic [PB-1:0]          r_phase;
    logic [PB-1:0]          r_step;
    sae_pkg::t_cmd          r_cmd;
    t_stage                 r_tgt;
    logic [L-1:0]           r_len;
    logic [31:0]            r_pa;
    logic [31:0]            r_pb;
    logic [GB-1:0]          r_gain;
    logic signed [31:0]     r_prod;
    logic                   r_out_valid;
    logic signed [SB-1:0]   r_out_sample;
    logic [GB-1:0]          r_out_gain;

    logic [XB-1:0]          w_idx;
    logic [FB-1:0]          w_frac;
    logic [FB:0]            w_inv;
    logic [AW-1:0]          w_raddr;
    logic [GB-1:0]          w_rdata;
    logic                   w_we;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [PB-1:0]          w_quot;
    logic [31:0]            w_pa;
    logic [31:0]            w_pb;
    logic [31:0]            w_sum;
    logic [GB-1:0]          w_shape;
    logic signed [31:0]     w_prod;
    logic                   w_out_free;

    assign w_idx   = r_phase[PB-1 -: XB];
    assign w_frac  = r_phase[PB-XB-1 -: FB];
    assign w_inv   = {1'b1, {FB{1'b0}}} - {1'b0, w_frac};
    assign w_raddr = (r_state == S_RDB) ? AW'({1'b0, w_idx}) + AW'(1) : AW'({1'b0, w_idx});
    assign w_we    = (r_state == S_DISPATCH) && (r_cmd.kind == sae_pkg::CMD_TWRITE);

    assign w_pa    = w_rdata * w_inv;
    assign w_pb    = w_rdata * w_frac;
    assign w_sum   = r_pa + r_pb;
    assign w_shape = w_sum[FB +: GB];
    assign w_prod  = $signed({1'b0, r_gain}) * r_cmd.sample;

    assign w_div_start = (r_state == S_DSTART);
    assign w_out_free  = !r_out_valid || i_tready;
    assign o_q_pop     = (r_state == S_FETCH) && i_q_valid;

    sae_ram #(
        .WIDTH (GB),
        .DEPTH (sae_pkg::TABLE_DEPTH)
    ) u_shape (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cmd.index),
        .i_wdata (r_cmd.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sae_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (r_len),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_stage     <= ST_IDLE;
            r_remaining <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_EMIT a free output register is refilled below
            if (i_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_FETCH: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (r_cmd.kind)
                        sae_pkg::CMD_TWRITE: begin
                            r_state <= S_FETCH;
                        end
                        sae_pkg::CMD_NOTE_ON: begin
                            priority if (r_stage == ST_IDLE || i_cfg.fade == '0) begin
                                r_tgt   <= ST_ATTACK;
                                r_len   <= at_least_two(i_cfg.attack);
                                r_state <= S_DSTART;
                            end else if (r_stage != ST_FADE) begin
                                r_tgt   <= ST_FADE;
                                r_len   <= i_cfg.fade;
                                r_state <= S_DSTART;
                            end else begin
                                // retrigger during a forced fade is ignored
                                r_state <= S_FETCH;
                            end
                        end
                        default: begin
                            priority if (r_stage == ST_IDLE) begin
                                r_gain  <= '0;
                                r_state <= S_MULG;
                            end else if (r_remaining != '0) begin
                                r_state <= S_RDA;
                            end else begin
                                unique case (r_stage)
                                    ST_ATTACK: begin
                                        if (i_cfg.hold != '0) begin
                                            r_tgt <= ST_HOLD;
                                            r_len <= i_cfg.hold;
                                        end else begin
                                            r_tgt <= ST_DECAY;
                                            r_len <= at_least_two(i_cfg.decay);
                                        end
                                        r_state <= S_DSTART;
                                    end
                                    ST_HOLD: begin
                                        r_tgt   <= ST_DECAY;
                                        r_len   <= at_least_two(i_cfg.decay);
                                        r_state <= S_DSTART;
                                    end
                                    ST_FADE: begin
                                        r_tgt   <= ST_ATTACK;
                                        r_len   <= at_least_two(i_cfg.attack);
                                        r_state <= S_DSTART;
                                    end
                                    default: begin
                                        // decay ran out: this sample is already silent
                                        r_stage <= ST_IDLE;
                                        r_gain  <= '0;
                                        r_state <= S_MULG;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_stage     <= r_tgt;
                        r_remaining <= r_len;
                        r_phase     <= '0;
                        r_step      <= (r_len == L'(1)) ? '1 : w_quot;
                        r_state     <= (r_cmd.kind == sae_pkg::CMD_SAMPLE) ? S_RDA : S_FETCH;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_pa    <= w_pa;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_pb    <= w_pb;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    unique case (r_stage)
                        ST_ATTACK: r_gain <= w_shape;
                        ST_HOLD:   r_gain <= sae_pkg::FULL_LEVEL;
                        default:   r_gain <= sae_pkg::FULL_LEVEL - w_shape;
                    endcase
                    r_state <= S_MULG;
                end
                S_MULG: begin
                    r_prod  <= w_prod;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_prod[SB +: SB];
                        r_out_gain   <= r_gain;
                        if (r_stage != ST_IDLE) begin
                            r_phase     <= r_phase + r_step;
                            r_remaining <= r_remaining - L'(1);
                        end
                        r_state <= S_FETCH;
                    end
                end
                default: begin
                    r_state <= S_FETCH;
                end
            endcase
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_gain   = r_out_gain;

endmodule

// ===== hdl/shaped_ahd_envelope.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// s_axis    in         tvalid / tready         tuser: op; tdata: sample, index, value
// m_axis    out        tvalid / tready         tdata: sample_out, gain
// cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample loads the output register after its input transaction once the sequencer is
// free; crossing a stage boundary first runs the serial phase-step divider (33 quotient
// bits). A note-on that starts a stage also runs the divider; a table write or an
// ignored note-on does not. Reset (i_rst_n low at a clock edge) loads the length
// registers and idles the envelope; the shape table holds nothing defined until written.
// A two-entry queue decouples input from the sequencer, which stalls only at its output
// step while a result waits on m_axis_tready.
module shaped_ahd_envelope (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [15:0] sample_in, [24:16] table_index, [39:25] table_value
    input  logic [sae_pkg::S_TDATA_BITS-1:0]        s_axis_tdata,
    // [1:0] op
    input  logic [sae_pkg::OP_BITS-1:0]             s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [15:0] sample_out, [30:16] gain, [31] zero
    output logic [sae_pkg::M_TDATA_BITS-1:0]        m_axis_tdata,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [sae_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [sae_pkg::LENGTH_BITS-1:0]         i_cfg_data
);

    localparam int SB = sae_pkg::SAMPLE_BITS;
    localparam int GB = sae_pkg::GAIN_BITS;

    sae_pkg::t_cfg          r_cfg;
    sae_pkg::t_cmd          w_push_cmd;
    sae_pkg::t_cmd          w_q_cmd;
    logic                   w_push;
    logic                   w_q_full;
    logic                   w_q_valid;
    logic                   w_q_pop;
    logic signed [SB-1:0]   w_sample;
    logic [GB-1:0]          w_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack <= sae_pkg::ATTACK_RESET;
            r_cfg.hold   <= sae_pkg::HOLD_RESET;
            r_cfg.decay  <= sae_pkg::DECAY_RESET;
            r_cfg.fade   <= sae_pkg::FADE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sae_pkg::CFG_ATTACK: r_cfg.attack <= i_cfg_data;
                sae_pkg::CFG_HOLD:   r_cfg.hold   <= i_cfg_data;
                sae_pkg::CFG_DECAY:  r_cfg.decay  <= i_cfg_data;
                sae_pkg::CFG_FADE:   r_cfg.fade   <= i_cfg_data;
                default:             r_cfg        <= r_cfg;
            endcase
        end
    end

    sae_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    sae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    sae_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_sample  (w_sample),
        .o_gain    (w_gain)
    );

    assign m_axis_tdata = {1'b0, w_gain, w_sample};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import sae_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam int SEGMENTS = 9;
    localparam int ITEMS_PER_SEGMENT = 20;
    localparam logic [OP_BITS-1:0] OP_UNUSED = OP_BITS'(3);
    localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
    localparam logic [63:0] PHASE_CIRCLE = 64'h1_0000_0000;

    typedef enum logic [2:0] {
        ENV_IDLE,
        ENV_ATTACK,
        ENV_HOLD,
        ENV_DECAY,
        ENV_FADE
    } env_stage_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0] level;
        logic [GAIN_BITS-1:0]   gain;
    } scaled_t;

    // Tracks the envelope state and holds the scaled samples still owed by the block.
    class gain_envelope;
        logic [LENGTH_BITS-1:0] attack_len;
        logic [LENGTH_BITS-1:0] hold_len;
        logic [LENGTH_BITS-1:0] decay_len;
        logic [LENGTH_BITS-1:0] fade_len;
        env_stage_t             stage;
        logic [LENGTH_BITS-1:0] remaining;
        logic [PHASE_BITS-1:0]  phase;
        logic [PHASE_BITS-1:0]  phase_step;
        logic [GAIN_BITS-1:0]   shape_tbl [TABLE_DEPTH];
        scaled_t                scaled_samples [$];
        int                     mismatches;

        function new();
            attack_len = ATTACK_RESET;
            hold_len   = HOLD_RESET;
            decay_len  = DECAY_RESET;
            fade_len   = FADE_RESET;
            stage      = ENV_IDLE;
            remaining  = '0;
            phase      = '0;
            phase_step = '0;
            mismatches = 0;
            foreach (shape_tbl[i]) shape_tbl[i] = '0;
        endfunction

        function logic [LENGTH_BITS-1:0] at_least_two(logic [LENGTH_BITS-1:0] n);
            return (n < 2) ? LENGTH_BITS'(2) : n;
        endfunction

        function void enter(env_stage_t st, logic [LENGTH_BITS-1:0] n);
            stage      = st;
            remaining  = n;
            phase      = '0;
            phase_step = (n < 2) ? '1 : PHASE_BITS'(PHASE_CIRCLE / n);
        endfunction

        // Interpolate linearly between neighboring table entries on the phase.
        function logic [GAIN_BITS-1:0] shape_at(logic [PHASE_BITS-1:0] ph);
            int     seg;
            longint frac;
            longint lo;
            longint hi;
            seg  = int'(ph[31:24]);
            frac = longint'(ph[23:8]);
            lo   = longint'(shape_tbl[seg]);
            hi   = longint'(shape_tbl[seg + 1]);
            return GAIN_BITS'((lo * (FRAC_ONE - frac) + hi * frac) >> FRAC_BITS);
        endfunction

        function void set_length(logic [CFG_IDX_BITS-1:0] idx, logic [LENGTH_BITS-1:0] data);
            case (idx)
                CFG_ATTACK: attack_len = data;
                CFG_HOLD:   hold_len = data;
                CFG_DECAY:  decay_len = data;
                CFG_FADE:   fade_len = data;
                default: ;
            endcase
        endfunction

        function void apply_item(logic [OP_BITS-1:0] op, logic [SAMPLE_BITS-1:0] smp,
                                 logic [TABLE_AW-1:0] idx, logic [GAIN_BITS-1:0] val);
            logic [GAIN_BITS-1:0] g;
            longint               prod;
            scaled_t              r;
            case (op)
                OP_NOTE_ON: begin
                    if (stage == ENV_IDLE || fade_len == 0)
                        enter(ENV_ATTACK, at_least_two(attack_len));
                    else if (stage != ENV_FADE)
                        enter(ENV_FADE, fade_len);
                end
                OP_TWRITE: begin
                    if (idx <= TABLE_SEGMENTS) shape_tbl[idx] = val;
                end
                OP_SAMPLE: begin
                    // Move on through every stage that has run out before scaling.
                    while (stage != ENV_IDLE && remaining == 0) begin
                        case (stage)
                            ENV_ATTACK: begin
                                if (hold_len != 0) enter(ENV_HOLD, hold_len);
                                else enter(ENV_DECAY, at_least_two(decay_len));
                            end
                            ENV_HOLD: enter(ENV_DECAY, at_least_two(decay_len));
                            ENV_FADE: enter(ENV_ATTACK, at_least_two(attack_len));
                            default:  stage = ENV_IDLE;
                        endcase
                    end
                    if (stage == ENV_IDLE) begin
                        r.level = '0;
                        r.gain  = '0;
                    end else begin
                        if (stage == ENV_ATTACK) g = shape_at(phase);
                        else if (stage == ENV_HOLD) g = FULL_LEVEL;
                        else g = FULL_LEVEL - shape_at(phase);
                        prod       = longint'(g) * longint'($signed(smp));
                        r.level    = SAMPLE_BITS'(prod >>> FRAC_BITS);
                        r.gain     = g;
                        phase      = phase + phase_step;
                        remaining  = remaining - 1'b1;
                    end
                    scaled_samples.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_output(logic [M_TDATA_BITS-1:0] tdata);
            scaled_t want;
            if (scaled_samples.size() == 0) begin
                $error("unexpected output transaction: tdata 0x%08h", tdata);
                mismatches++;
                return;
            end
            want = scaled_samples.pop_front();
            if (tdata[15:0] !== want.level) begin
                $error("sample_out: expected %0d, got %0d",
                       $signed(want.level), $signed(tdata[15:0]));
                mismatches++;
            end
            if (tdata[30:16] !== want.gain) begin
                $error("gain: expected %0d, got %0d", want.gain, tdata[30:16]);
                mismatches++;
            end
            if (tdata[31] !== 1'b0) begin
                $error("pad bit: expected 0, got %b", tdata[31]);
                mismatches++;
            end
        endfunction

        function int pending();
            return scaled_samples.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [S_TDATA_BITS-1:0]   s_axis_tdata = '0;
    logic [OP_BITS-1:0]        s_axis_tuser = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_axis_tdata;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [LENGTH_BITS-1:0]    i_cfg_data = '0;

    gain_envelope env = new();
    int src_idle_pct = 22;
    int sink_idle_pct = 79;
    int stall_cycles = 0;

    shaped_ahd_envelope dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) env.check_output(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic [OP_BITS-1:0] op, input logic [SAMPLE_BITS-1:0] smp,
                             input logic [TABLE_AW-1:0] idx, input logic [GAIN_BITS-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, idx, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        env.apply_item(op, smp, idx, val);
        @(negedge i_clk);
    endtask

    // Leaves the valid high; the caller drops it after the last register.
    task automatic write_length(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [LENGTH_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        env.set_length(idx, data);
        @(negedge i_clk);
    endtask

    // Note-ons and table writes leave no result, so give them time to finish.
    task automatic drain_and_pause();
        s_axis_tvalid <= 1'b0;
        while (env.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        if ($urandom_range(9) != 0) return SAMPLE_BITS'($urandom);
        case ($urandom_range(3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    // Note-on followed by a run of items of random length, up to the stage lengths plus 8 and at most 120, with noise.
    task automatic run_bursts(input int target);
        int     sent;
        int     run_len;
        int     pick;
        longint span;
        logic [TABLE_AW-1:0] idx;
        sent = 0;
        while (sent < target) begin
            send_item(OP_NOTE_ON, SAMPLE_BITS'($urandom), TABLE_AW'($urandom),
                      GAIN_BITS'($urandom));
            sent++;
            if ($urandom_range(9) < 3) begin
                send_item(OP_NOTE_ON, SAMPLE_BITS'($urandom), TABLE_AW'($urandom),
                          GAIN_BITS'($urandom));
                sent++;
            end
            span = longint'(env.at_least_two(env.attack_len)) + env.hold_len +
                   env.at_least_two(env.decay_len) + env.fade_len + 8;
            if (span > 120) span = 120;
            run_len = $urandom_range(int'(span));
            if (run_len > target - sent) run_len = target - sent;
            repeat (run_len) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    if ($urandom_range(4) == 0)
                        idx = TABLE_AW'($urandom_range(TABLE_DEPTH, (1 << TABLE_AW) - 1));
                    else
                        idx = TABLE_AW'($urandom_range(TABLE_SEGMENTS));
                    send_item(OP_TWRITE, SAMPLE_BITS'($urandom), idx, GAIN_BITS'($urandom));
                end else if (pick < 11) begin
                    send_item(OP_UNUSED, SAMPLE_BITS'($urandom), TABLE_AW'($urandom),
                              GAIN_BITS'($urandom));
                end else if (pick < 14) begin
                    send_item(OP_NOTE_ON, SAMPLE_BITS'($urandom), TABLE_AW'($urandom),
                              GAIN_BITS'($urandom));
                end else begin
                    send_item(OP_SAMPLE, pick_sample(), TABLE_AW'($urandom),
                              GAIN_BITS'($urandom));
                end
                sent++;
            end
        end
    endtask

    initial begin
        logic [LENGTH_BITS-1:0] lens [4];
        logic [GAIN_BITS-1:0]   val;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle envelope: output and gain stay zero.
        send_item(OP_SAMPLE, 16'h7FFF, '0, '0);
        send_item(OP_SAMPLE, 16'h8000, '1, '1);
        send_item(OP_SAMPLE, 16'h0000, '0, '0);

        // Fill the whole shape table before any note can read it.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) val = '0;
            else if (i >= TABLE_SEGMENTS - 1) val = FULL_LEVEL;
            else val = GAIN_BITS'($urandom);
            send_item(OP_TWRITE, SAMPLE_BITS'($urandom), TABLE_AW'(i), val);
        end
        send_item(OP_TWRITE, '1, TABLE_AW'(TABLE_DEPTH), FULL_LEVEL);
        send_item(OP_TWRITE, '0, '1, FULL_LEVEL);
        send_item(OP_UNUSED, '1, '1, '1);

        // Attack at reset lengths with full-scale, small and zero samples.
        send_item(OP_NOTE_ON, '0, '0, '0);
        send_item(OP_SAMPLE, 16'h7FFF, '0, '0);
        send_item(OP_SAMPLE, 16'h8000, '0, '0);
        send_item(OP_SAMPLE, 16'hFFFF, '0, '0);
        send_item(OP_SAMPLE, 16'h0001, '0, '0);
        send_item(OP_SAMPLE, 16'h0000, '0, '0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin
                    src_idle_pct  = 22;
                    sink_idle_pct = 79;
                end
                1: begin
                    src_idle_pct  = 79;
                    sink_idle_pct = 22;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            drain_and_pause();
            case (seg)
                0: lens = '{LENGTH_BITS'(0), LENGTH_BITS'(0), LENGTH_BITS'(1), LENGTH_BITS'(0)};
                1: lens = '{LENGTH_BITS'(2), LENGTH_BITS'(1), LENGTH_BITS'(2), LENGTH_BITS'(1)};
                2: lens = '{'1, '1, '1, '1};
                5: foreach (lens[k]) lens[k] = LENGTH_BITS'($urandom);
                default: begin
                    lens[0] = LENGTH_BITS'($urandom_range(30));
                    lens[1] = LENGTH_BITS'($urandom_range(15));
                    lens[2] = LENGTH_BITS'($urandom_range(30));
                    lens[3] = LENGTH_BITS'($urandom_range(12));
                end
            endcase
            write_length(CFG_ATTACK, lens[0]);
            write_length(CFG_HOLD, lens[1]);
            write_length(CFG_DECAY, lens[2]);
            write_length(CFG_FADE, lens[3]);
            write_length(CFG_IDX_BITS'($urandom_range(int'(CFG_FADE) + 1,
                                                      (1 << CFG_IDX_BITS) - 1)),
                         LENGTH_BITS'($urandom));
            i_cfg_valid <= 1'b0;
            run_bursts(ITEMS_PER_SEGMENT);
        end

        s_axis_tvalid <= 1'b0;
        while (env.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (env.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
